// ===== src/integer_to_radix_ascii_digits_unit_macros.svh =====
// Assertion macros shared by the integer to radix ASCII digits unit.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef INTEGER_TO_RADIX_ASCII_DIGITS_UNIT_MACROS_SVH
`define INTEGER_TO_RADIX_ASCII_DIGITS_UNIT_MACROS_SVH

// Same-cycle implication.
`define ITRAD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("itrad assertion failed");

// Next-cycle implication.
`define ITRAD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("itrad assertion failed");

`endif

// ===== src/itrad_pkg.sv =====
// Package for the integer to radix ASCII digits unit.
// Holds radix codes, register indexes, config struct, state type and helpers.
package itrad_pkg;

    localparam int MAX_WIDTH_DEF = 64;
    localparam int VALUE_W       = 64;
    localparam int ADDR_W        = 3;
    localparam int DATA_W        = 32;

    localparam logic [6:0] CHAR_0 = 7'h30;
    localparam logic [6:0] CHAR_9 = 7'h39;
    localparam logic [6:0] CHAR_A = 7'h61;
    localparam logic [6:0] CHAR_F = 7'h66;

    // Register index taken from paddr[2]; registers are word aligned.
    localparam logic REG_WORD_LENGTH = 1'b0;
    localparam logic REG_RADIX_MODE  = 1'b1;

    localparam logic [1:0] WORD_LENGTH_RESET = 2'd3;

    typedef enum logic [1:0] {
        RADIX_HEX  = 2'd0,
        RADIX_OCT  = 2'd1,
        RADIX_BIN  = 2'd2,
        RADIX_NONE = 2'd3
    } radix_t;

    typedef struct packed {
        logic [1:0] word_length;
        radix_t     radix_mode;
    } cfg_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } shift_state_t;

    function automatic logic [6:0] digit_ascii(logic [3:0] d);
        logic [6:0] d7;
        d7 = {3'b000, d};
        return (d > 4'd9) ? (d7 - 7'd10 + CHAR_A) : (d7 + CHAR_0);
    endfunction

    function automatic logic [VALUE_W-1:0] width_mask(int w);
        logic [VALUE_W-1:0] m;
        if (w >= VALUE_W)
            m = '1;
        else
            m = (VALUE_W'(1) << w) - VALUE_W'(1);
        return m;
    endfunction

endpackage

// ===== src/itrad_cfg_regs.sv =====
// APB register file for the integer to radix ASCII digits unit.
// Depends on itrad_pkg for register indexes and the config struct.
module itrad_cfg_regs
    import itrad_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Decode on the word index only; byte offsets within a word alias it.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (paddr[2])
                REG_WORD_LENGTH: cfg_next.word_length = pwdata[1:0];
                REG_RADIX_MODE:  cfg_next.radix_mode  = radix_t'(pwdata[1:0]);
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.word_length <= WORD_LENGTH_RESET;
            cfg_reg.radix_mode  <= RADIX_HEX;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_WORD_LENGTH: prdata = DATA_W'(cfg_reg.word_length);
            REG_RADIX_MODE:  prdata = DATA_W'(cfg_reg.radix_mode);
            default:         prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/itrad_digit_shifter.sv =====
// Digit-serial engine: shifts one radix digit per cycle (output stall permitting)
// out of the top of the loaded word, drops leading zeros and holds each character
// in an output register. Depends on itrad_pkg and the unit's assertion macros.
`include "integer_to_radix_ascii_digits_unit_macros.svh"

module itrad_digit_shifter
    import itrad_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [MAX_WIDTH+2:0]               start_data,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]     start_ndig,
    input  radix_t                             start_radix,
    output logic                               busy,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [7:0]                         m_axis_tdata,  // [6:0] digit_char, [7] zero
    output logic                               m_axis_tlast   // last_digit
);

    localparam int SR_W  = MAX_WIDTH + 3;
    localparam int CNT_W = $clog2(MAX_WIDTH + 1);

    shift_state_t     state_reg, state_next;
    logic [SR_W-1:0]  sr_reg, sr_next, sr_shift;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    radix_t           radix_reg, radix_next;
    logic             started_reg, started_next;
    logic             out_valid_reg, out_valid_next;
    logic [6:0]       out_char_reg, out_char_next;
    logic             out_last_reg, out_last_next;

    logic [3:0]       digit;
    logic             is_last;
    logic             emit;
    logic             slot_free;
    logic             step;

    logic             char_is_digit;
    logic             char_is_letter;
    logic             idle_with_last;

    // Current digit, shift and handshake decisions
    always_comb
    begin
        case (radix_reg)
            RADIX_HEX:
            begin
                digit    = sr_reg[SR_W-1 -: 4];
                sr_shift = {sr_reg[SR_W-5:0], 4'b0000};
            end
            RADIX_OCT:
            begin
                digit    = {1'b0, sr_reg[SR_W-1 -: 3]};
                sr_shift = {sr_reg[SR_W-4:0], 3'b000};
            end
            default:
            begin
                digit    = {3'b000, sr_reg[SR_W-1]};
                sr_shift = {sr_reg[SR_W-2:0], 1'b0};
            end
        endcase
        is_last   = (cnt_reg == CNT_W'(1));
        // The final digit always goes out, so zero still yields one '0'.
        emit      = started_reg || (digit != 4'd0) || is_last;
        slot_free = !out_valid_reg || m_axis_tready;
        step      = (state_reg == ST_RUN) && (slot_free || !emit);
        busy      = (state_reg == ST_RUN);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (step && is_last)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and output register
    always_comb
    begin
        sr_next        = sr_reg;
        cnt_next       = cnt_reg;
        radix_next     = radix_reg;
        started_next   = started_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;

        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        if (start)
        begin
            sr_next      = start_data;
            cnt_next     = start_ndig;
            radix_next   = start_radix;
            started_next = 1'b0;
        end
        else if (step)
        begin
            sr_next      = sr_shift;
            cnt_next     = cnt_reg - CNT_W'(1);
            started_next = started_reg || emit;
            if (emit)
            begin
                out_valid_next = 1'b1;
                out_char_next  = digit_ascii(digit);
                out_last_next  = is_last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            started_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            started_reg   <= started_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sr_reg       <= sr_next;
        cnt_reg      <= cnt_next;
        radix_reg    <= radix_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_char_reg};
    assign m_axis_tlast  = out_last_reg;

    assign char_is_digit  = (out_char_reg >= CHAR_0) && (out_char_reg <= CHAR_9);
    assign char_is_letter = (out_char_reg >= CHAR_A) && (out_char_reg <= CHAR_F);
    assign idle_with_last = (state_reg == ST_IDLE) && out_valid_reg && out_last_reg;

    `ITRAD_ASSERT_IMPL(a_start_when_idle, start, state_reg == ST_IDLE)
    `ITRAD_ASSERT_IMPL(a_run_has_digits, state_reg == ST_RUN, cnt_reg != '0)
    `ITRAD_ASSERT_NEXT(a_last_ends_run, step && is_last, idle_with_last)
    `ITRAD_ASSERT_IMPL(a_char_range, out_valid_reg, char_is_digit || char_is_letter)

endmodule

// ===== src/integer_to_radix_ascii_digits_unit.sv =====
// Engine: one digit position per cycle while the output is not stalled (hex
// ceil(W/4), octal ceil(W/3), binary W for word length W); leading zeros give no
// beat. A nonzero top digit goes out via the shift register and output register.
// Input: the single digit shift register takes one item at a time; s_axis_tready
// is low while it is busy, so output stalls also hold off the next item.
// Reset: rst_n clears config to 64-bit hex and empties engine and output.
module integer_to_radix_ascii_digits_unit
    import itrad_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [VALUE_W-1:0] s_axis_tdata,   // [63:0] value
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [7:0]         m_axis_tdata,   // [6:0] digit_char, [7] zero
    output logic               m_axis_tlast,   // last_digit
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    localparam int SR_W  = MAX_WIDTH + 3;
    localparam int CNT_W = $clog2(MAX_WIDTH + 1);

    localparam int W8  = (MAX_WIDTH < 8)  ? MAX_WIDTH : 8;
    localparam int W16 = (MAX_WIDTH < 16) ? MAX_WIDTH : 16;
    localparam int W32 = (MAX_WIDTH < 32) ? MAX_WIDTH : 32;
    localparam int W64 = (MAX_WIDTH < 64) ? MAX_WIDTH : 64;

    localparam int NDH [4] = '{(W8 + 3) / 4, (W16 + 3) / 4, (W32 + 3) / 4, (W64 + 3) / 4};
    localparam int NDO [4] = '{(W8 + 2) / 3, (W16 + 2) / 3, (W32 + 2) / 3, (W64 + 2) / 3};
    localparam int NDB [4] = '{W8, W16, W32, W64};

    localparam logic [VALUE_W-1:0] WMASK [4] =
        '{width_mask(W8), width_mask(W16), width_mask(W32), width_mask(W64)};

    cfg_t                cfg;
    logic                busy;
    logic                accept;
    logic                start;
    logic [VALUE_W-1:0]  masked;
    logic [SR_W-1:0]     base;
    logic [SR_W-1:0]     cand_h [4];
    logic [SR_W-1:0]     cand_o [4];
    logic [SR_W-1:0]     cand_b [4];
    logic [SR_W-1:0]     start_data;
    logic [CNT_W-1:0]    start_ndig;

    itrad_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign s_axis_tready = !busy;
    assign accept        = s_axis_tvalid && s_axis_tready;
    // Unsupported radix: accept the beat and drop it.
    assign start         = accept && (cfg.radix_mode != RADIX_NONE);

    // Mask to word length and left-align so the top digit sits at the MSB.
    always_comb
    begin
        masked = s_axis_tdata & WMASK[cfg.word_length];
        base   = SR_W'(masked[MAX_WIDTH-1:0]);
        for (int i = 0; i < 4; i++)
        begin
            cand_h[i] = base << (SR_W - 4 * NDH[i]);
            cand_o[i] = base << (SR_W - 3 * NDO[i]);
            cand_b[i] = base << (SR_W - NDB[i]);
        end
        case (cfg.radix_mode)
            RADIX_HEX:
            begin
                start_data = cand_h[cfg.word_length];
                start_ndig = CNT_W'(NDH[cfg.word_length]);
            end
            RADIX_OCT:
            begin
                start_data = cand_o[cfg.word_length];
                start_ndig = CNT_W'(NDO[cfg.word_length]);
            end
            default:
            begin
                start_data = cand_b[cfg.word_length];
                start_ndig = CNT_W'(NDB[cfg.word_length]);
            end
        endcase
    end

    itrad_digit_shifter #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_shifter (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .start_data    (start_data),
        .start_ndig    (start_ndig),
        .start_radix   (cfg.radix_mode),
        .busy          (busy),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== tb/integer_to_radix_ascii_digits_unit_test.sv =====
// Testbench for the integer to radix ASCII digits unit: drives values over the stream
// input, writes the format registers over APB and checks every digit beat out.
// Depends on itrad_pkg and integer_to_radix_ascii_digits_unit.
`timescale 1ns / 100ps

module integer_to_radix_ascii_digits_unit_test
    import itrad_pkg::*;
;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE_TICKS = 80;
    localparam int LONG_HOLD    = 400;
    localparam int SHOWN_ERRORS = 10;

    typedef struct {
        logic [6:0] ch;
        logic       last;
    } digit_beat_t;

    // Digit predictor and in-order store of the beats still owed by the block.
    class digit_checker;
        logic [1:0]  word_len = WORD_LENGTH_RESET;
        radix_t      radix    = RADIX_HEX;
        digit_beat_t owed_digits[$];
        int          errors   = 0;

        function int pending();
            return owed_digits.size();
        endfunction

        function void flag_error(string msg);
            errors++;
            if (errors <= SHOWN_ERRORS)
                $display("ERROR @%0t: %s", $realtime, msg);
        endfunction

        // Work out the digits of one accepted value under the current format.
        function void expect_digits(logic [63:0] value);
            int unsigned width;
            int unsigned step;
            logic [3:0]  dmask;
            logic [63:0] w;
            logic [3:0]  digs[$];
            digit_beat_t b;
            width = 8 << word_len;
            if (width > MAX_WIDTH_DEF)
                width = MAX_WIDTH_DEF;
            case (radix)
                RADIX_HEX: begin step = 4; dmask = 4'hf; end
                RADIX_OCT: begin step = 3; dmask = 4'h7; end
                RADIX_BIN: begin step = 1; dmask = 4'h1; end
                default:   return;
            endcase
            w = (width >= 64) ? value : (value & ((64'd1 << width) - 64'd1));
            // Zero still yields one digit
            do
            begin
                digs.push_front(4'(w) & dmask);
                w = w >> step;
            end while (w != 64'd0);
            foreach (digs[i])
            begin
                b.ch   = (digs[i] > 4'd9) ? (CHAR_A + 7'(digs[i]) - 7'd10)
                                          : (CHAR_0 + 7'(digs[i]));
                b.last = (i == digs.size() - 1);
                owed_digits.push_back(b);
            end
        endfunction

        function void take_digit(logic [7:0] data, logic last);
            digit_beat_t b;
            if (owed_digits.size() == 0)
            begin
                flag_error($sformatf("unexpected beat data=%h last=%b", data, last));
                return;
            end
            b = owed_digits.pop_front();
            if (data[6:0] !== b.ch)
                flag_error($sformatf("digit_char exp=%h got=%h", b.ch, data[6:0]));
            if (last !== b.last)
                flag_error($sformatf("last_digit exp=%b got=%b", b.last, last));
            if (data[7] !== 1'b0)
                flag_error($sformatf("pad bit exp=0 got=%b", data[7]));
        endfunction
    endclass

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;   // [63:0] value
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // [6:0] digit_char, [7] zero
    logic        m_axis_tlast;         // last_digit
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    logic [DATA_W-1:0] prdata;
    logic        pready;

    digit_checker checker_h = new();
    int unsigned  cycles     = 0;
    bit           src_idles  = 1'b0;
    bit           sink_idles = 1'b0;
    bit           hold_sink  = 1'b0;

    integer_to_radix_ascii_digits_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                checker_h.expect_digits(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                checker_h.take_digit(m_axis_tdata, m_axis_tlast);
        end
    end

    // Output side: random stall bursts, plus one long hold on request.
    initial
    begin
        int unsigned stall;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_sink)
            begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_sink = 1'b0;
            end
            else if (sink_idles && $urandom_range(0, 4) == 0)
            begin
                m_axis_tready <= 1'b0;
                stall = $urandom_range(1, 19);
                repeat (stall - 1) @(posedge clk);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic send_value(input logic [63:0] value);
        if (src_idles && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    // Drop valid and wait until every owed digit has arrived.
    task automatic drain_digits();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (checker_h.pending() != 0);
    endtask

    task automatic reg_write(input logic idx, input logic [1:0] val);
        logic [DATA_W-1:0] d;
        d      = $urandom();
        d[1:0] = val;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= d;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (idx == REG_WORD_LENGTH)
            checker_h.word_len = val;
        else
            checker_h.radix = radix_t'(val);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_format(input logic [1:0] wl, input radix_t rdx);
        drain_digits();
        // Let the engine go idle before the format changes
        repeat (SETTLE_TICKS) @(posedge clk);
        reg_write(REG_WORD_LENGTH, wl);
        reg_write(REG_RADIX_MODE, rdx);
    endtask

    function automatic logic [63:0] rand_value();
        case ($urandom_range(0, 5))
            0:       return {$urandom(), $urandom()};
            1:       return {$urandom(), $urandom()} >> $urandom_range(0, 63);
            2:       return 64'd0;
            3:       return '1;
            4:       return 64'd1 << $urandom_range(0, 63);
            default: return {$urandom(), $urandom()} << $urandom_range(8, 63);
        endcase
    endfunction

    initial
    begin
        int unsigned count;
        radix_t      rdx;
        logic [1:0]  wl;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset format: 64-bit hex
        send_value(64'd0);
        send_value('1);
        send_value(64'h0123_4567_89ab_cdef);
        send_value(64'h8000_0000_0000_0000);
        set_format(2'd3, RADIX_BIN);
        send_value('1);
        send_value(64'd1);
        send_value(64'd0);
        set_format(2'd3, RADIX_OCT);
        send_value('1);
        send_value(64'h8000_0000_0000_0000);
        // Bits above the word length are masked away
        set_format(2'd0, RADIX_HEX);
        send_value(64'hffff_ffff_ffff_ff00);
        send_value('1);
        set_format(2'd0, RADIX_OCT);
        send_value(64'h0000_0000_0000_00ff);
        send_value(64'h0000_0000_0000_0100);
        set_format(2'd1, RADIX_BIN);
        send_value(64'h0000_0000_0000_ffff);
        send_value(64'h0000_0000_0001_8000);
        set_format(2'd2, RADIX_OCT);
        send_value(64'h0000_0000_ffff_ffff);
        set_format(2'd2, RADIX_HEX);
        send_value(64'h0000_0001_0000_0000);
        send_value(64'h1234_5678_dead_beef);
        // Unsupported radix gives no digits
        set_format(2'd3, RADIX_NONE);
        send_value('1);
        send_value(64'd0);

        for (int phase = 0; phase < 10; phase++)
        begin
            wl  = $urandom_range(0, 3);
            rdx = ($urandom_range(0, 7) == 0) ? RADIX_NONE : radix_t'($urandom_range(0, 2));
            if (phase == 2)
            begin
                wl  = 2'd3;
                rdx = RADIX_BIN;
            end
            set_format(wl, rdx);
            src_idles  = (phase < 9) && $urandom_range(0, 3) != 0;
            sink_idles = (phase < 9) && $urandom_range(0, 3) != 0;
            // Back up the output so the engine stalls its input
            if (phase == 2)
                hold_sink = 1'b1;
            count = (rdx == RADIX_NONE) ? 4 : $urandom_range(14, 22);
            for (int n = 0; n < count; n++)
            begin
                if (phase == 5 && n == count / 2)
                    drain_digits();
                send_value(rand_value());
            end
        end

        drain_digits();
        repeat (SETTLE_TICKS) @(posedge clk);
        if (checker_h.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
